FILE: src/sas_pkg.sv
// Package for the selective ACK scoreboard.
// Holds sizes, operation and status codes, beat structs and lane context.
// Used by every module of the block but sas_ram; depends on nothing.
package sas_pkg;

    localparam int CHUNKS  = 1024;
    localparam int LANES   = 8;
    localparam int ROWS    = CHUNKS / LANES;
    localparam int IDX_W   = $clog2(CHUNKS);
    localparam int LANE_W  = $clog2(LANES);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ROWD_W  = 2 * LANES;
    localparam int PCNT_W  = LANE_W + 1;

    localparam logic [31:0] FINISHED_WORD = 32'hFFFF_FFFF;
    localparam logic [15:0] OFFSET_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_MARK_SENT = 2'd0,
        OP_ACK_HEAD  = 2'd1,
        OP_BITMAP    = 2'd2,
        OP_ADVANCE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_UNSENT   = 2'd0,
        ST_SENT     = 2'd1,
        ST_RECEIVED = 2'd2,
        ST_SPARE    = 2'd3
    } t_chunk_st;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  chunk_index;
        logic [31:0] ack_word;
        logic [7:0]  bitmap_byte;
    } t_item;

    typedef struct packed {
        logic [10:0] newly_received;
        logic [10:0] received_total;
        logic        all_received;
        logic        finished_marker;
        logic        resend_header;
        logic        header_acknowledged;
        logic [9:0]  next_position;
        logic        wrapped;
    } t_result;

    // Per-item context shared by all lanes
    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] act;
        logic [IDX_W-1:0] cidx;
        logic [CNT_W-1:0] limit;
        logic [IDX_W-1:0] start;
        logic [15:0]      off;
        logic [15:0]      len;
        logic [7:0]       bits;
        logic [IDX_W-1:0] cursor;
    } t_ctx;

    // What one lane reports to the merge stage
    typedef struct packed {
        logic promoted;
        logic cand_hi;
        logic cand_lo;
    } t_lane_res;

    typedef struct packed {
        logic [PCNT_W-1:0] count;
        logic              hi_found;
        logic [LANE_W-1:0] hi_lane;
        logic              lo_found;
        logic [LANE_W-1:0] lo_lane;
    } t_merge_res;

endpackage

FILE: src/sas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module sas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sas_lane.sv
// One lane of the scoreboard: updates one chunk status of the current row.
// Depends on sas_pkg.
module sas_lane (
    input  sas_pkg::t_ctx                  i_ctx,
    input  logic [sas_pkg::IDX_W-1:0]      i_idx,
    input  logic [1:0]                     i_st,
    output logic [1:0]                     o_st,
    output sas_pkg::t_lane_res             o_res
);

    logic                      in_act;
    logic [sas_pkg::IDX_W-1:0] rel_idx;
    logic [16:0]               rel_pos;
    logic                      is_sent;
    logic                      is_rcvd;

    assign in_act  = {1'b0, i_idx} < i_ctx.act;
    assign rel_idx = i_idx - i_ctx.start;
    assign rel_pos = {1'b0, i_ctx.off} + {{(17 - sas_pkg::IDX_W){1'b0}}, rel_idx};
    assign is_sent = i_st == sas_pkg::ST_SENT;
    assign is_rcvd = i_st == sas_pkg::ST_RECEIVED;

    // apply the operation to this chunk
    always_comb begin
        o_st           = i_st;
        o_res.promoted = 1'b0;
        o_res.cand_hi  = 1'b0;
        o_res.cand_lo  = 1'b0;
        case (i_ctx.op)
            sas_pkg::OP_MARK_SENT: begin
                if (in_act && i_idx == i_ctx.cidx && !is_rcvd) begin
                    o_st = sas_pkg::ST_SENT;
                end
            end
            sas_pkg::OP_ACK_HEAD: begin
                if ({1'b0, i_idx} < i_ctx.limit && is_sent) begin
                    o_st           = sas_pkg::ST_RECEIVED;
                    o_res.promoted = 1'b1;
                end
            end
            sas_pkg::OP_BITMAP: begin
                if (in_act && i_idx >= i_ctx.start && rel_idx < sas_pkg::IDX_W'(8)
                        && rel_pos < {1'b0, i_ctx.len}
                        && i_ctx.bits[rel_idx[2:0]] && is_sent) begin
                    o_st           = sas_pkg::ST_RECEIVED;
                    o_res.promoted = 1'b1;
                end
            end
            default: begin
                o_res.cand_hi = in_act && !is_rcvd && i_idx > i_ctx.cursor;
                o_res.cand_lo = in_act && !is_rcvd && i_idx <= i_ctx.cursor;
            end
        endcase
    end

endmodule

FILE: src/sas_merge.sv
// Merge stage: counts promotions and finds the first cursor candidates.
// Depends on sas_pkg.
module sas_merge (
    input  sas_pkg::t_lane_res  i_lane [sas_pkg::LANES],
    output sas_pkg::t_merge_res o_res
);

    // count and pick the lowest lane with a candidate
    always_comb begin
        o_res = '0;
        for (int l = sas_pkg::LANES - 1; l >= 0; l--) begin
            o_res.count = o_res.count + sas_pkg::PCNT_W'(i_lane[l].promoted);
            if (i_lane[l].cand_hi) begin
                o_res.hi_found = 1'b1;
                o_res.hi_lane  = sas_pkg::LANE_W'(l);
            end
            if (i_lane[l].cand_lo) begin
                o_res.lo_found = 1'b1;
                o_res.lo_lane  = sas_pkg::LANE_W'(l);
            end
        end
    end

endmodule

FILE: src/selective_ack_scoreboard_core.sv
// Top level of the selective ACK scoreboard.
// Depends on sas_pkg, sas_ram, sas_lane and sas_merge.
//
// An item is taken when start is high and busy is low; its result appears on
// o_result for one cycle with o_done, and must be taken then. Chunk status is
// kept in a RAM of rows of eight chunks, and eight lanes handle one row at a
// time: read, then modify and write back. A mark-sent item touches one
// row, a bitmap byte at most two, an ACK head word the rows below its base and
// a cursor advance every row of the active range. Per-row valid flops make the
// RAM read as all unsent after reset, so no clearing pass is needed. A
// total_chunks write is taken while the block is idle.
module selective_ack_scoreboard_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sas_pkg::t_item   i_item,
    output logic             o_done,
    output sas_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [10:0]      i_cfg_data
);

    sas_pkg::t_state r_state, n_state;

    logic [10:0]               r_total;
    logic [sas_pkg::CNT_W-1:0] r_rcvd;
    logic                      r_header;
    logic [13:0]               r_base;
    logic [15:0]               r_len;
    logic [15:0]               r_off;
    logic [sas_pkg::IDX_W-1:0] r_cursor;
    logic [sas_pkg::ROWS-1:0]  r_row_valid;

    sas_pkg::t_ctx             r_ctx;
    logic [sas_pkg::ROW_W-1:0] r_row, r_last_row;
    logic [sas_pkg::CNT_W-1:0] r_newly;
    logic                      r_finished, r_resend;
    logic                      r_hi_found, r_lo_found;
    logic [sas_pkg::IDX_W-1:0] r_hi_idx, r_lo_idx;
    logic                      r_done;
    sas_pkg::t_result          r_result;

    logic                       accept;
    logic                       has_rows;
    logic [sas_pkg::ROW_W-1:0]  first_row, last_row;
    logic [sas_pkg::CNT_W-1:0]  act;
    logic [sas_pkg::CNT_W-1:0]  limit;
    logic [16:0]                bm_start;
    logic [16:0]                bm_end;
    logic [16:0]                off_next;
    logic                       is_finished;
    logic                       ram_we;
    logic [sas_pkg::ROWD_W-1:0] ram_q, row_in, row_out;
    sas_pkg::t_lane_res         lane_res [sas_pkg::LANES];
    sas_pkg::t_merge_res        merge_res;
    logic [sas_pkg::IDX_W-1:0]  adv_pos;
    logic                       adv_wrap;

    assign accept      = start && !busy;
    assign act         = (r_total < 11'(sas_pkg::CHUNKS)) ? r_total
                                                          : 11'(sas_pkg::CHUNKS);
    assign is_finished = i_item.ack_word == sas_pkg::FINISHED_WORD;
    assign limit       = ({1'b0, i_item.ack_word[29:16]} < {4'b0, act})
                         ? sas_pkg::CNT_W'(i_item.ack_word[29:16]) : act;
    assign bm_start    = {3'b0, r_base} + {1'b0, r_off};
    assign bm_end      = ((bm_start + 17'd7) < {6'b0, act}) ? (bm_start + 17'd7)
                                                            : ({6'b0, act} - 17'd1);
    assign off_next    = {1'b0, r_off} + 17'd8;

    // decide which rows the item walks
    always_comb begin
        has_rows  = 1'b0;
        first_row = '0;
        last_row  = '0;
        case (i_item.operation)
            sas_pkg::OP_MARK_SENT: begin
                has_rows  = {1'b0, i_item.chunk_index} < act;
                first_row = i_item.chunk_index[sas_pkg::IDX_W-1:sas_pkg::LANE_W];
                last_row  = first_row;
            end
            sas_pkg::OP_ACK_HEAD: begin
                has_rows  = !is_finished && limit != '0;
                last_row  = 7'((limit - 11'd1) >> sas_pkg::LANE_W);
            end
            sas_pkg::OP_BITMAP: begin
                has_rows  = r_off < r_len && bm_start < {6'b0, act};
                first_row = bm_start[sas_pkg::IDX_W-1:sas_pkg::LANE_W];
                last_row  = bm_end[sas_pkg::IDX_W-1:sas_pkg::LANE_W];
            end
            default: begin
                has_rows  = act != '0;
                last_row  = 7'((act - 11'd1) >> sas_pkg::LANE_W);
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sas_pkg::S_IDLE: begin
                if (accept) n_state = has_rows ? sas_pkg::S_READ : sas_pkg::S_DONE;
            end
            sas_pkg::S_READ: n_state = sas_pkg::S_MOD;
            sas_pkg::S_MOD: begin
                n_state = (r_row == r_last_row) ? sas_pkg::S_DONE : sas_pkg::S_READ;
            end
            sas_pkg::S_DONE: n_state = sas_pkg::S_IDLE;
            default: n_state = sas_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy        = 1'b1;
        ram_we      = 1'b0;
        unique case (r_state)
            sas_pkg::S_IDLE: busy   = 1'b0;
            sas_pkg::S_MOD:  ram_we = 1'b1;
            default: ;
        endcase
    end
    assign o_cfg_ready = !busy;

    // chunk status rows
    sas_ram #(
        .WIDTH(sas_pkg::ROWD_W),
        .DEPTH(sas_pkg::ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (row_out),
        .i_raddr (r_row),
        .o_rdata (ram_q)
    );

    // a row never written reads as all unsent
    assign row_in = r_row_valid[r_row] ? ram_q : '0;

    for (genvar l = 0; l < sas_pkg::LANES; l++) begin : g_lane
        sas_lane u_lane (
            .i_ctx (r_ctx),
            .i_idx ({r_row, sas_pkg::LANE_W'(l)}),
            .i_st  (row_in[2*l +: 2]),
            .o_st  (row_out[2*l +: 2]),
            .o_res (lane_res[l])
        );
    end

    sas_merge u_merge (
        .i_lane (lane_res),
        .o_res  (merge_res)
    );

    // final cursor for an advance
    always_comb begin
        if (r_ctx.act == '0) begin
            adv_pos  = '0;
            adv_wrap = 1'b0;
        end else if (r_hi_found) begin
            adv_pos  = r_hi_idx;
            adv_wrap = 1'b0;
        end else if (r_lo_found) begin
            adv_pos  = r_lo_idx;
            adv_wrap = 1'b1;
        end else begin
            adv_pos  = ({1'b0, r_cursor} >= r_ctx.act) ? 10'(r_ctx.act - 11'd1)
                                                       : r_cursor;
            adv_wrap = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sas_pkg::S_IDLE;
            r_total     <= 11'(sas_pkg::CHUNKS);
            r_rcvd      <= '0;
            r_header    <= 1'b0;
            r_base      <= '0;
            r_len       <= '0;
            r_off       <= '0;
            r_cursor    <= '0;
            r_row_valid <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= r_state == sas_pkg::S_DONE;
            if (i_cfg_valid && o_cfg_ready) begin
                r_total <= i_cfg_data;
            end
            // register updates made on accept
            if (accept && i_item.operation == sas_pkg::OP_ACK_HEAD && !is_finished) begin
                r_header <= r_header | i_item.ack_word[30];
                r_base   <= i_item.ack_word[29:16];
                r_len    <= i_item.ack_word[15:0];
                r_off    <= '0;
            end
            if (accept && i_item.operation == sas_pkg::OP_BITMAP && r_off < r_len) begin
                r_off <= off_next[16] ? sas_pkg::OFFSET_MAX : off_next[15:0];
            end
            if (ram_we) begin
                r_row_valid[r_row] <= 1'b1;
                r_rcvd <= r_rcvd + sas_pkg::CNT_W'(merge_res.count);
            end
            if (r_state == sas_pkg::S_DONE && r_ctx.op == sas_pkg::OP_ADVANCE) begin
                r_cursor <= adv_pos;
            end
        end
    end

    // per-item datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctx.op     <= sas_pkg::t_op'(i_item.operation);
            r_ctx.act    <= act;
            r_ctx.cidx   <= i_item.chunk_index;
            r_ctx.limit  <= limit;
            r_ctx.start  <= bm_start[sas_pkg::IDX_W-1:0];
            r_ctx.off    <= r_off;
            r_ctx.len    <= r_len;
            r_ctx.bits   <= i_item.bitmap_byte;
            r_ctx.cursor <= r_cursor;
            r_row        <= first_row;
            r_last_row   <= last_row;
            r_newly      <= '0;
            r_hi_found   <= 1'b0;
            r_lo_found   <= 1'b0;
            r_hi_idx     <= '0;
            r_lo_idx     <= '0;
            r_finished   <= i_item.operation == sas_pkg::OP_ACK_HEAD && is_finished;
            r_resend     <= i_item.operation == sas_pkg::OP_ACK_HEAD && !is_finished
                            && !i_item.ack_word[30];
        end
        if (ram_we) begin
            r_newly <= r_newly + sas_pkg::CNT_W'(merge_res.count);
            r_row   <= r_row + 7'd1;
            if (!r_hi_found && merge_res.hi_found) begin
                r_hi_found <= 1'b1;
                r_hi_idx   <= {r_row, merge_res.hi_lane};
            end
            if (!r_lo_found && merge_res.lo_found) begin
                r_lo_found <= 1'b1;
                r_lo_idx   <= {r_row, merge_res.lo_lane};
            end
        end
        // hold the result beat
        if (r_state == sas_pkg::S_DONE) begin
            r_result.newly_received      <= r_newly;
            r_result.received_total      <= r_rcvd;
            r_result.all_received        <= r_rcvd == r_total;
            r_result.finished_marker     <= r_finished;
            r_result.resend_header       <= r_resend;
            r_result.header_acknowledged <= r_header;
            r_result.next_position       <= (r_ctx.op == sas_pkg::OP_ADVANCE) ? adv_pos
                                                                             : r_cursor;
            r_result.wrapped             <= r_ctx.op == sas_pkg::OP_ADVANCE && adv_wrap;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: src/sas_checker.sv
// Port-level checks for the selective ACK scoreboard, bound to the top level.
// Depends on sas_pkg and selective_ack_scoreboard_core.
module sas_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input sas_pkg::t_result o_result
);

    // an accepted item keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("not busy after accept");

    // a result beat only appears once the block is idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result beat while busy");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    // received count never exceeds the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.received_total <= 11'(sas_pkg::CHUNKS))
        else $error("received count out of range");

    // reset leaves the block idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done) else $error("not idle after reset");

endmodule

bind selective_ack_scoreboard_core sas_checker u_sas_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

FILE: tb/tb.sv
// Testbench for selective_ack_scoreboard_core: drives command beats and config
// writes, predicts each result in a scoreboard class and checks every done beat.
// Depends on sas_pkg and the RTL of the block.
module tb;

    // Scoreboard: predicts chunk status tracking and holds expected results
    class sack_scoreboard;
        sas_pkg::t_chunk_st chunk_st [sas_pkg::CHUNKS];
        int unsigned        rx_count;
        bit                 hdr_seen;
        int unsigned        base;
        int unsigned        len;
        int unsigned        bm_off;
        int unsigned        cur;
        int unsigned        total;
        sas_pkg::t_result   pending [$];
        int                 errors;

        function void clear();
            foreach (chunk_st[i]) chunk_st[i] = sas_pkg::ST_UNSENT;
            rx_count = 0; hdr_seen = 0; base = 0; len = 0; bm_off = 0; cur = 0;
            total = 1024; errors = 0;
        endfunction

        function int unsigned active();
            return (total < sas_pkg::CHUNKS) ? total : sas_pkg::CHUNKS;
        endfunction

        function int unsigned promote(int unsigned idx);
            if (idx >= active() || chunk_st[idx] != sas_pkg::ST_SENT) return 0;
            chunk_st[idx] = sas_pkg::ST_RECEIVED;
            rx_count++;
            return 1;
        endfunction

        // Note an accepted command beat and queue its expected result
        function void note_item(sas_pkg::t_item it);
            sas_pkg::t_result r;
            int unsigned      act, newly, steps, off;
            bit               fin, rsd, wrp;
            act = active(); newly = 0; fin = 0; rsd = 0; wrp = 0;
            case (sas_pkg::t_op'(it.operation))
                sas_pkg::OP_MARK_SENT: begin
                    if (it.chunk_index < act
                            && chunk_st[it.chunk_index] != sas_pkg::ST_RECEIVED)
                        chunk_st[it.chunk_index] = sas_pkg::ST_SENT;
                end
                sas_pkg::OP_ACK_HEAD: begin
                    if (it.ack_word == sas_pkg::FINISHED_WORD) begin
                        fin = 1;
                    end else begin
                        if (!it.ack_word[30]) rsd = 1;
                        else hdr_seen = 1;
                        base = it.ack_word[29:16];
                        len = it.ack_word[15:0];
                        bm_off = 0;
                        for (int unsigned i = 0; i < base && i < act; i++)
                            newly += promote(i);
                    end
                end
                sas_pkg::OP_BITMAP: begin
                    if (bm_off < len) begin
                        for (int unsigned b = 0; b < 8; b++) begin
                            off = bm_off + b;
                            if (off < len && it.bitmap_byte[b]) newly += promote(base + off);
                        end
                        bm_off += 8;
                        if (bm_off > sas_pkg::OFFSET_MAX) bm_off = sas_pkg::OFFSET_MAX;
                    end
                end
                default: begin
                    if (act == 0) begin
                        cur = 0;
                    end else begin
                        steps = 0;
                        do begin
                            cur++;
                            if (cur >= act) begin
                                cur = 0;
                                wrp = 1;
                            end
                            steps++;
                        end while (chunk_st[cur] == sas_pkg::ST_RECEIVED && steps < act);
                    end
                end
            endcase
            r.newly_received      = newly[10:0];
            r.received_total      = rx_count[10:0];
            r.all_received        = (rx_count == total);
            r.finished_marker     = fin;
            r.resend_header       = rsd;
            r.header_acknowledged = hdr_seen;
            r.next_position       = cur[9:0];
            r.wrapped             = wrp;
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        // Compare a done beat with the oldest expectation
        task check_result(sas_pkg::t_result got);
            sas_pkg::t_result w;
            if (pending.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.newly_received != w.newly_received)
                report("newly_received", got.newly_received, w.newly_received);
            if (got.received_total != w.received_total)
                report("received_total", got.received_total, w.received_total);
            if (got.all_received != w.all_received)
                report("all_received", got.all_received, w.all_received);
            if (got.finished_marker != w.finished_marker)
                report("finished_marker", got.finished_marker, w.finished_marker);
            if (got.resend_header != w.resend_header)
                report("resend_header", got.resend_header, w.resend_header);
            if (got.header_acknowledged != w.header_acknowledged)
                report("header_acknowledged", got.header_acknowledged,
                       w.header_acknowledged);
            if (got.next_position != w.next_position)
                report("next_position", got.next_position, w.next_position);
            if (got.wrapped != w.wrapped)
                report("wrapped", got.wrapped, w.wrapped);
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    sas_pkg::t_item   i_item;
    logic             o_done;
    sas_pkg::t_result o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [10:0]      i_cfg_data;

    sack_scoreboard sb;
    int          burst_left;
    int unsigned chunk_span;

    selective_ack_scoreboard_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Check every done beat at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // Send one command beat; hold start until the block takes it
    task automatic send_item(sas_pkg::t_item it);
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        start  <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_item(it);
        burst_left--;
        @(negedge i_clk);
        if (burst_left <= 0) start <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // Write total_chunks while idle
    task automatic write_total(int unsigned val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val[10:0];
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.total = val & 32'h7FF;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic sas_pkg::t_item mk(sas_pkg::t_op op, int unsigned idx,
                                          logic [31:0] w, logic [7:0] b);
        sas_pkg::t_item it;
        it.operation   = op;
        it.chunk_index = idx[9:0];
        it.ack_word    = w;
        it.bitmap_byte = b;
        return it;
    endfunction

    function automatic sas_pkg::t_item rand_item();
        sas_pkg::t_item it;
        int unsigned    k;
        it = mk(sas_pkg::OP_MARK_SENT, $urandom, $urandom, 8'($urandom));
        k = $urandom_range(0, 99);
        // Mostly well-formed traffic inside the active span, some noise
        if (k < 40) begin
            it.operation   = sas_pkg::OP_MARK_SENT;
            it.chunk_index = 10'($urandom_range(0, chunk_span - 1));
        end else if (k < 55) begin
            it.operation = sas_pkg::OP_ACK_HEAD;
            if (k < 52) begin
                it.ack_word[29:16] = 14'($urandom_range(0, chunk_span + 4));
                it.ack_word[15:0]  = 16'($urandom_range(0, 40));
            end
            if (k == 54) it.ack_word = sas_pkg::FINISHED_WORD;
        end else if (k < 85) begin
            it.operation = sas_pkg::OP_BITMAP;
        end else begin
            it.operation = sas_pkg::OP_ADVANCE;
        end
        return it;
    endfunction

    initial begin
        sb = new();
        sb.clear();
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        burst_left  = 0;
        chunk_span  = 1024;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every operation and the special cases
        write_total(16);
        chunk_span = 24;
        send_item(mk(sas_pkg::OP_ADVANCE, 0, 0, 0));
        send_item(mk(sas_pkg::OP_MARK_SENT, 0, 0, 0));
        send_item(mk(sas_pkg::OP_MARK_SENT, 1023, 0, 0));
        send_item(mk(sas_pkg::OP_MARK_SENT, 3, 0, 0));
        send_item(mk(sas_pkg::OP_MARK_SENT, 5, 0, 0));
        send_item(mk(sas_pkg::OP_MARK_SENT, 9, 0, 0));
        send_item(mk(sas_pkg::OP_ACK_HEAD, 0, 32'h8003_0010, 0));
        send_item(mk(sas_pkg::OP_MARK_SENT, 0, 0, 0));
        send_item(mk(sas_pkg::OP_BITMAP, 0, 0, 8'hFF));
        send_item(mk(sas_pkg::OP_BITMAP, 0, 0, 8'hFF));
        send_item(mk(sas_pkg::OP_BITMAP, 0, 0, 8'hFF));
        send_item(mk(sas_pkg::OP_ACK_HEAD, 0, sas_pkg::FINISHED_WORD, 0));
        send_item(mk(sas_pkg::OP_ACK_HEAD, 0, 32'h7FFF_FFFF, 0));
        send_item(mk(sas_pkg::OP_ACK_HEAD, 0, 32'h4000_FFFF, 0));
        send_item(mk(sas_pkg::OP_BITMAP, 0, 0, 8'h00));
        send_item(mk(sas_pkg::OP_ADVANCE, 0, 0, 0));
        send_item(mk(sas_pkg::OP_ADVANCE, 0, 0, 0));
        write_total(1);
        send_item(mk(sas_pkg::OP_ADVANCE, 0, 0, 0));
        write_total(0);
        send_item(mk(sas_pkg::OP_ADVANCE, 0, 0, 0));
        send_item(mk(sas_pkg::OP_MARK_SENT, 0, 0, 0));
        write_total(1024);
        send_item(mk(sas_pkg::OP_ACK_HEAD, 0, 32'h0000_0000, 0));
        send_item(mk(sas_pkg::OP_ACK_HEAD, 0, 32'hC400_0000, 0));
        send_item(mk(sas_pkg::OP_ADVANCE, 0, 0, 0));

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_total(1024);
                1: write_total(40);
                2: write_total(2047);
                3: write_total(1);
                4: write_total($urandom_range(2, 200));
                default: write_total(1024);
            endcase
            chunk_span = (sb.total < 64) ? sb.total + 8 : 64;
            for (int n = 0; n < 95; n++) begin
                send_item(rand_item());
                if (ph == 2 && n == 40) drain();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("tb: failure");
        $finish;
    end
endmodule

FILE: sim.f
src/sas_pkg.sv
src/sas_ram.sv
src/sas_lane.sv
src/sas_merge.sv
src/selective_ack_scoreboard_core.sv
src/sas_checker.sv
tb/tb.sv
